// ----- rtl/xm_pattern_cell_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pattern cell decoder
// Concurrent checks on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef XM_PATTERN_CELL_DECODER_UNIT_ASSERT_SVH
`define XM_PATTERN_CELL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define XMPCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define XMPCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XMPCD_ASSERT_IMP(lbl, ante, cons, msg)
`define XMPCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/xmpcd_pkg.sv -----
// ----------------------------------------------------------------------------
// xmpcd_pkg
// Types and constants shared by the pattern cell decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xmpcd_pkg;

  // input word
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] row_index;
    logic [4:0] channel_index;
    logic [7:0] note_value;
    logic [7:0] instrument_number;
    logic [7:0] volume_value;
    logic [3:0] effect_code;
    logic [7:0] fx_param;
    logic       note_cleared;
    logic [1:0] effect_class;
    logic       pattern_last;
  } out_word_t;

  // configuration registers
  typedef struct packed {
    logic [5:0] stored_chans;
    logic [5:0] kept_channels;
    logic [8:0] pattern_rows;
    logic [7:0] note_off_code;
    logic [7:0] max_note;
  } cfg_t;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STORED_CHANS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEPT_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFF_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NOTE      = 3'd4;

  localparam logic [5:0] RST_STORED_CHANS  = 6'd8;
  localparam logic [5:0] RST_KEPT_CHANNELS = 6'd8;
  localparam logic [8:0] RST_PATTERN_ROWS  = 9'd64;
  localparam logic [7:0] RST_NOTE_OFF_CODE = 8'd97;
  localparam logic [7:0] RST_MAX_NOTE      = 8'd96;

  // cell fields in stream order
  localparam int CELL_FIELDS = 5;
  localparam int FLD_NOTE    = 0;
  localparam int FLD_INSTR   = 1;
  localparam int FLD_VOL     = 2;
  localparam int FLD_FXTYPE  = 3;
  localparam int FLD_FXPARAM = 4;

  localparam logic [2:0] PHASE_LEAD = 3'd0;
  localparam logic [2:0] PHASE_END  = 3'd5;

  // finished cell handed from front to back
  typedef struct packed {
    logic [7:0]                  row;
    logic [4:0]                  chan;
    logic [CELL_FIELDS-1:0][7:0] fields;
    logic                        last;
  } cell_rec_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // volume column
  localparam logic [7:0] VOL_NONE  = 8'hFF;
  localparam logic [7:0] VOL_BASE  = 8'h10;
  localparam logic [7:0] VOL_TOP   = 8'h50;
  localparam logic [3:0] VC_SLIDE_DN = 4'h6;
  localparam logic [3:0] VC_SLIDE_UP = 4'h7;
  localparam logic [3:0] VC_PAN      = 4'hC;
  localparam logic [3:0] VC_PORTA    = 4'hF;

  // output effect commands
  localparam logic [3:0] CMD_NONE     = 4'h0;
  localparam logic [3:0] CMD_PORTA    = 4'h3;
  localparam logic [3:0] CMD_PAN      = 4'h8;
  localparam logic [3:0] CMD_VOLSLIDE = 4'hA;
  localparam logic [3:0] CMD_SETVOL   = 4'hC;
  localparam logic [3:0] CMD_EXT      = 4'hE;

  // extended effect types
  localparam logic [7:0] XT_DIRECT_TOP = 8'h0F;
  localparam logic [7:0] XT_GLOBAL_VOL = 8'h10;
  localparam logic [7:0] XT_GVOL_SLIDE = 8'h11;
  localparam logic [7:0] XT_KEY_OFF    = 8'h14;
  localparam logic [7:0] XT_PAN_SLIDE  = 8'h19;
  localparam logic [7:0] XT_RETRIG     = 8'h1B;
  localparam logic [7:0] XT_TREMOR     = 8'h1D;
  localparam logic [7:0] XT_EXTRA_FINE = 8'h21;

  localparam logic [7:0] GVOL_LIMIT    = 8'h40;
  localparam logic [3:0] EXT_RETRIG_HI = 4'h9;
  localparam logic [3:0] EXT_FINE_UP   = 4'h1;
  localparam logic [3:0] EXT_FINE_DN   = 4'h2;

  typedef enum logic [1:0] {
    FX_DIRECT  = 2'd0,
    FX_APPROX  = 2'd1,
    FX_DROPPED = 2'd2,
    FX_VOLCOL  = 2'd3
  } fx_class_t;

endpackage

`default_nettype wire

// ----- rtl/xmpcd_front.sv -----
// ----------------------------------------------------------------------------
// xmpcd_front
// Byte parser: gathers packed or plain cells and walks row/channel position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmpcd_front #(
  parameter int MAX_ROWS     = 256,
  parameter int MAX_CHANNELS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    accept,
  input  xmpcd_pkg::in_word_t    in_data,
  input  xmpcd_pkg::cfg_t        cfg,
  output logic                   push,
  output xmpcd_pkg::cell_rec_t   push_rec
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [8:0] ROWS_LIM = 9'(MAX_ROWS);
  localparam logic [5:0] CH_LIM   = 6'(MAX_CHANNELS);

  typedef logic [xmpcd_pkg::CELL_FIELDS-1:0][7:0] cell_t;

  logic [2:0]      phase_r,  phase_nxt;
  logic            packed_r, packed_nxt;
  logic [4:0]      mask_r,   mask_nxt;
  cell_t           fields_r, fields_nxt;
  logic [ROW_W-1:0] row_r,   row_nxt;
  logic [CH_W-1:0] chan_r,   chan_nxt;
  logic            done_r,   done_nxt;

  cell_t      cell_w;
  logic       fin;
  logic [4:0] sel;
  logic [8:0] rows;
  logic [5:0] fch, kch;
  logic       emit;

  // effective limits
  always_comb begin
    rows = (cfg.pattern_rows == 9'd0) ? 9'd1 :
           ((cfg.pattern_rows > ROWS_LIM) ? ROWS_LIM : cfg.pattern_rows);
    fch  = (cfg.stored_chans == 6'd0) ? 6'd1 :
           ((cfg.stored_chans > CH_LIM) ? CH_LIM : cfg.stored_chans);
    kch  = (cfg.kept_channels > fch) ? fch : cfg.kept_channels;
  end

  assign emit = 6'(chan_r) < kch;

  always_comb begin
    phase_nxt  = phase_r;
    packed_nxt = packed_r;
    mask_nxt   = mask_r;
    fields_nxt = fields_r;
    row_nxt    = row_r;
    chan_nxt   = chan_r;
    done_nxt   = done_r;
    cell_w     = fields_r;
    fin        = 1'b0;
    sel        = 5'd0;
    // an end word after a finished pattern is dropped
    if (accept && !(done_r && in_data.kind)) begin
      done_nxt = 1'b0;
      if (in_data.kind) begin
        fin = 1'b1;
        if (phase_r == xmpcd_pkg::PHASE_LEAD || !packed_r) begin
          cell_w = '0;
        end
      end else if (phase_r == xmpcd_pkg::PHASE_LEAD) begin
        cell_w = '0;
        if (in_data.byte_value[7]) begin
          packed_nxt = 1'b1;
          mask_nxt   = in_data.byte_value[4:0];
          if (in_data.byte_value[4:0] == 5'd0) begin
            fin = 1'b1;
          end
        end else begin
          packed_nxt = 1'b0;
          cell_w[xmpcd_pkg::FLD_NOTE] = in_data.byte_value;
        end
        phase_nxt = 3'd1;
      end else if (packed_r) begin
        // lowest pending mask bit takes this byte
        sel = mask_r & (~mask_r + 5'd1);
        for (int i = 0; i < xmpcd_pkg::CELL_FIELDS; i++) begin
          if (sel[i]) begin
            cell_w[i] = in_data.byte_value;
          end
        end
        mask_nxt = mask_r & ~sel;
        if (mask_nxt == 5'd0) begin
          fin = 1'b1;
        end
      end else begin
        for (int i = 0; i < xmpcd_pkg::CELL_FIELDS; i++) begin
          if (phase_r == 3'(i)) begin
            cell_w[i] = in_data.byte_value;
          end
        end
        phase_nxt = phase_r + 3'd1;
        if (phase_nxt >= xmpcd_pkg::PHASE_END) begin
          fin = 1'b1;
        end
      end
      fields_nxt = cell_w;
      if (fin) begin
        phase_nxt  = xmpcd_pkg::PHASE_LEAD;
        packed_nxt = 1'b0;
        mask_nxt   = 5'd0;
        fields_nxt = '0;
        if (6'(chan_r) + 6'd1 >= fch) begin
          chan_nxt = '0;
          if (9'(row_r) + 9'd1 >= rows) begin
            row_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            row_nxt = ROW_W'(9'(row_r) + 9'd1);
          end
        end else begin
          chan_nxt = CH_W'(6'(chan_r) + 6'd1);
        end
      end
    end
  end

  assign push            = fin && emit;
  assign push_rec.row    = 8'(row_r);
  assign push_rec.chan   = 5'(chan_r);
  assign push_rec.fields = cell_w;
  assign push_rec.last   = (9'(row_r) == rows - 9'd1) && (6'(chan_r) == kch - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= xmpcd_pkg::PHASE_LEAD;
      packed_r <= 1'b0;
      mask_r   <= 5'd0;
      fields_r <= '0;
      row_r    <= '0;
      chan_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      packed_r <= packed_nxt;
      mask_r   <= mask_nxt;
      fields_r <= fields_nxt;
      row_r    <= row_nxt;
      chan_r   <= chan_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xmpcd_queue.sv -----
// ----------------------------------------------------------------------------
// xmpcd_queue
// Small FIFO of finished cells between the parser and the mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmpcd_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  xmpcd_pkg::cell_rec_t   push_rec,
  input  wire                    pop,
  output logic                   full,
  output logic                   empty,
  output xmpcd_pkg::cell_rec_t   head_rec
);

  xmpcd_pkg::cell_rec_t mem_r [xmpcd_pkg::QUEUE_DEPTH];

  logic [xmpcd_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [xmpcd_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [xmpcd_pkg::QCNT_W-1:0] cnt_r,  cnt_nxt;

  assign full     = cnt_r == xmpcd_pkg::QCNT_W'(xmpcd_pkg::QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign head_rec = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + xmpcd_pkg::QCNT_W'(push) - xmpcd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xmpcd_back.sv -----
// ----------------------------------------------------------------------------
// xmpcd_back
// Cell mapper: note check, volume column and effect remap, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmpcd_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    head_valid,
  input  xmpcd_pkg::cell_rec_t   head_rec,
  input  xmpcd_pkg::cfg_t        cfg,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output xmpcd_pkg::out_word_t   out_data
);

  logic                 valid_r, valid_nxt;
  xmpcd_pkg::out_word_t data_r,  data_nxt;

  logic [7:0] note, vbyte, ftype, fparam;
  logic [7:0] vol, vpar, par;
  logic [3:0] vcode, code, lo, hi;
  logic [3:0] vlo;
  xmpcd_pkg::fx_class_t cls;

  always_comb begin
    note   = head_rec.fields[xmpcd_pkg::FLD_NOTE];
    vbyte  = head_rec.fields[xmpcd_pkg::FLD_VOL];
    ftype  = head_rec.fields[xmpcd_pkg::FLD_FXTYPE];
    fparam = head_rec.fields[xmpcd_pkg::FLD_FXPARAM];
    vlo    = vbyte[3:0];
    hi     = fparam[7:4];
    lo     = fparam[3:0];

    // volume column
    vol   = xmpcd_pkg::VOL_NONE;
    vcode = xmpcd_pkg::CMD_NONE;
    vpar  = 8'd0;
    if (vbyte >= xmpcd_pkg::VOL_BASE) begin
      if (vbyte <= xmpcd_pkg::VOL_TOP) begin
        vol = vbyte - xmpcd_pkg::VOL_BASE;
      end else begin
        unique case (vbyte[7:4])
          xmpcd_pkg::VC_SLIDE_DN: begin
            vcode = xmpcd_pkg::CMD_VOLSLIDE;
            vpar  = {4'd0, vlo};
          end
          xmpcd_pkg::VC_SLIDE_UP: begin
            vcode = xmpcd_pkg::CMD_VOLSLIDE;
            vpar  = {vlo, 4'd0};
          end
          xmpcd_pkg::VC_PAN: begin
            vcode = xmpcd_pkg::CMD_PAN;
            vpar  = {vlo, vlo};  // lo * 17
          end
          xmpcd_pkg::VC_PORTA: begin
            vcode = xmpcd_pkg::CMD_PORTA;
            vpar  = {4'd0, vlo};
          end
          default: ;
        endcase
      end
    end

    // effect column wins over a volume-column effect
    code = xmpcd_pkg::CMD_NONE;
    par  = 8'd0;
    cls  = xmpcd_pkg::FX_DIRECT;
    if (ftype != 8'd0 || fparam != 8'd0) begin
      if (ftype <= xmpcd_pkg::XT_DIRECT_TOP) begin
        code = ftype[3:0];
        par  = fparam;
      end else begin
        cls = xmpcd_pkg::FX_APPROX;
        unique case (ftype)
          xmpcd_pkg::XT_GLOBAL_VOL: begin
            code = xmpcd_pkg::CMD_SETVOL;
            par  = (fparam < xmpcd_pkg::GVOL_LIMIT) ? fparam : xmpcd_pkg::GVOL_LIMIT;
          end
          xmpcd_pkg::XT_GVOL_SLIDE, xmpcd_pkg::XT_TREMOR: begin
            code = xmpcd_pkg::CMD_VOLSLIDE;
            par  = fparam;
          end
          xmpcd_pkg::XT_KEY_OFF: begin
            code = xmpcd_pkg::CMD_SETVOL;
          end
          xmpcd_pkg::XT_PAN_SLIDE: begin
            code = xmpcd_pkg::CMD_PAN;
            par  = fparam;
          end
          xmpcd_pkg::XT_RETRIG: begin
            code = xmpcd_pkg::CMD_EXT;
            par  = {xmpcd_pkg::EXT_RETRIG_HI, lo};
          end
          xmpcd_pkg::XT_EXTRA_FINE: begin
            if (hi == xmpcd_pkg::EXT_FINE_UP || hi == xmpcd_pkg::EXT_FINE_DN) begin
              code = xmpcd_pkg::CMD_EXT;
              par  = {hi, lo};
            end else begin
              cls = xmpcd_pkg::FX_DROPPED;
            end
          end
          default: cls = xmpcd_pkg::FX_DROPPED;
        endcase
      end
    end else if (vcode != xmpcd_pkg::CMD_NONE) begin
      code = vcode;
      par  = vpar;
      cls  = xmpcd_pkg::FX_VOLCOL;
    end

    data_nxt.row_index         = head_rec.row;
    data_nxt.channel_index     = head_rec.chan;
    data_nxt.instrument_number = head_rec.fields[xmpcd_pkg::FLD_INSTR];
    data_nxt.volume_value      = vol;
    data_nxt.effect_code       = code;
    data_nxt.fx_param          = par;
    data_nxt.effect_class      = cls;
    data_nxt.pattern_last      = head_rec.last;
    // key-off first, then the valid note range
    data_nxt.note_value        = 8'd0;
    data_nxt.note_cleared      = 1'b0;
    if (note == cfg.note_off_code) begin
      data_nxt.note_value = cfg.note_off_code;
    end else if (note >= 8'd1 && note <= cfg.max_note) begin
      data_nxt.note_value = note;
    end else if (note != 8'd0) begin
      data_nxt.note_cleared = 1'b1;
    end
  end

  assign pop       = head_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xm_pattern_cell_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// xm_pattern_cell_decoder_unit
// Tracker pattern cell unpacker: bytes in, mapped cells out.
// ----------------------------------------------------------------------------
//   channel  direction  ports                           word
//   in       input      in_valid / in_ready / in_data   kind, byte_value
//   out      output     out_valid / out_ready / out_data  one mapped cell
//   cfg      input      cfg_we / cfg_index / cfg_data   register write
//
// One byte word is taken every cycle while in_ready is high; a cell word
// reaches out through the queue and output register after the byte (or end
// word) that completes it. The parser finishes a cell in the cycle it takes
// the byte; the mapper registers it from the two-entry queue when out is free.
// in_ready drops only when the queue is full, i.e. after out stalls.
// Reset (rst_n low, synchronous) empties the queue and the output stage,
// returns the parser to the start of a pattern and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xm_pattern_cell_decoder_unit_assert.svh"

module xm_pattern_cell_decoder_unit #(
  parameter int MAX_ROWS     = 256,
  parameter int MAX_CHANNELS = 32
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  xmpcd_pkg::in_word_t                     in_data,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output xmpcd_pkg::out_word_t                    out_data,
  input  wire                                     cfg_we,
  input  wire  [xmpcd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [xmpcd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // configuration registers
  xmpcd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        xmpcd_pkg::REG_STORED_CHANS:  cfg_nxt.stored_chans  = cfg_data[5:0];
        xmpcd_pkg::REG_KEPT_CHANNELS: cfg_nxt.kept_channels = cfg_data[5:0];
        xmpcd_pkg::REG_PATTERN_ROWS:  cfg_nxt.pattern_rows  = cfg_data[8:0];
        xmpcd_pkg::REG_NOTE_OFF_CODE: cfg_nxt.note_off_code = cfg_data[7:0];
        xmpcd_pkg::REG_MAX_NOTE:      cfg_nxt.max_note      = cfg_data[7:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stored_chans  <= xmpcd_pkg::RST_STORED_CHANS;
      cfg_r.kept_channels <= xmpcd_pkg::RST_KEPT_CHANNELS;
      cfg_r.pattern_rows  <= xmpcd_pkg::RST_PATTERN_ROWS;
      cfg_r.note_off_code <= xmpcd_pkg::RST_NOTE_OFF_CODE;
      cfg_r.max_note      <= xmpcd_pkg::RST_MAX_NOTE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front -> queue -> back
  logic                 in_accept;
  logic                 q_push, q_pop, q_full, q_empty;
  xmpcd_pkg::cell_rec_t q_push_rec, q_head_rec;

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  xmpcd_front #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (q_push),
    .push_rec (q_push_rec)
  );

  xmpcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_rec (q_head_rec)
  );

  xmpcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head_rec   (q_head_rec),
    .cfg        (cfg_r),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // the parser never finishes a cell into a full queue
  `XMPCD_ASSERT_IMP(a_no_push_full, q_push, !q_full, "cell pushed into full queue")
  // a drained queue leaves the output empty after a handoff
  `XMPCD_ASSERT_NXT(a_drain_idle, out_valid && out_ready && q_empty, !out_valid, "stale output word")
  // a rising out_valid follows a queued cell
  `XMPCD_ASSERT_IMP(a_out_from_queue, $rose(out_valid), $past(!q_empty), "output without queued cell")

endmodule

`default_nettype wire
